// ----- hw/rtl/gpsh_pkg.sv -----
// Shared types, constants and the Hann table function for the granular pitch shifter.
// No dependencies; every other file refers to it by scoped names.
package gpsh_pkg;

  // default sizes, handed down from the top level
  localparam int DELAY_DEPTH_DEF = 8192;
  localparam int HANN_DEPTH_DEF  = 1024;

  // field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int WLEN_W     = 14;
  localparam int WINV_W     = 29;
  localparam int TRATIO_W   = 18;
  localparam int TGAIN_W    = 16;
  localparam int CFG_DATA_W = 29;
  localparam int CFG_IDX_W  = 2;

  // internal formats
  localparam int RATIO_W   = 22;  // Q2.20
  localparam int GAIN_W    = 21;  // Q1.20
  localparam int HANN_W    = 16;  // Q15, 0..32768
  localparam int MUL_B_W   = 31;
  localparam int ACC_W     = 33;
  localparam int GLIDE_SH  = 20;
  localparam int OUT_SH    = 35;
  localparam int FRAC_SH   = 16;
  localparam int WIN_MIN   = 16;

  localparam int RATIO_COEF = 1049;
  localparam int GAIN_COEF  = 5243;

  // reset values
  localparam logic [WLEN_W-1:0]   WLEN_RST   = WLEN_W'(2400);
  localparam logic [WINV_W-1:0]   WINV_RST   = WINV_W'(1789570);
  localparam logic [TRATIO_W-1:0] TRATIO_RST = TRATIO_W'(65536);
  localparam logic [TGAIN_W-1:0]  TGAIN_RST  = TGAIN_W'(32768);
  localparam logic [RATIO_W-1:0]  RATIO_RST  = RATIO_W'(1 << 20);
  localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(1 << 20);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LEN,
    CFG_WINDOW_INV,
    CFG_TARGET_RATIO,
    CFG_TARGET_GAIN
  } cfg_idx_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATIO_MUL,
    ST_RATIO_UPD,
    ST_PHASE_UPD,
    ST_TAP1,
    ST_TAP2,
    ST_HANN2,
    ST_MAC1,
    ST_MAC2,
    ST_ACC,
    ST_GAIN_MUL,
    ST_OUT
  } state_t;

  // shared multiplier operand selection
  typedef enum logic [2:0] {
    MUL_RATIO,
    MUL_GAIN,
    MUL_PHASE1,
    MUL_PHASE2,
    MUL_TAP1,
    MUL_TAP2,
    MUL_OUT
  } mul_op_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    mul_en;
    mul_op_t mul_op;
    logic    ld_sample;
    logic    upd_ratio;
    logic    upd_phase;
    logic    ld_tap1;
    logic    ld_tap2;
    logic    ld_hann2;
    logic    ld_d2;
    logic    ld_acc;
    logic    add_acc;
    logic    ld_out;
  } cmd_t;

  // status from the datapath
  typedef struct packed {
    logic out_full;
  } stat_t;

  // sin^2(pi*k/2^lg) in Q15 via an odd series to the 11th power; elaboration only
  function automatic logic [HANN_W-1:0] hann_q15(int unsigned k, int unsigned lg);
    longint unsigned depth;
    longint unsigned m;
    longint unsigned th;
    longint unsigned t;
    longint unsigned f;
    longint unsigned s;
    longint unsigned w;
    longint unsigned one;
    depth = 64'd1 << lg;
    one   = 64'd1 << 30;
    m     = (64'(k) <= depth - 64'(k)) ? 64'(k) : depth - 64'(k);
    th    = (64'd3373259426 * m) >> lg;
    t     = (th * th) >> 30;
    f     = one - t / 110;
    f     = one - ((t * f) >> 30) / 72;
    f     = one - ((t * f) >> 30) / 42;
    f     = one - ((t * f) >> 30) / 20;
    f     = one - ((t * f) >> 30) / 6;
    s     = (th * f) >> 30;
    w     = (s * s + (64'd1 << 44)) >> 45;
    if (w > 64'd32768) begin
      w = 64'd32768;
    end
    return HANN_W'(w);
  endfunction

endpackage

// ----- hw/rtl/gpsh_ctrl.sv -----
// Sequencer for the granular pitch shifter: steps one item through the datapath.
// Depends on gpsh_pkg for the state, command and status types.
module gpsh_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_ready,
  input  gpsh_pkg::stat_t stat,
  output gpsh_pkg::cmd_t  cmd
);

  gpsh_pkg::state_t state_r;
  gpsh_pkg::state_t state_nxt;
  logic             out_free;

  assign out_free = !stat.out_full || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gpsh_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gpsh_pkg::ST_IDLE:      if (in_valid) state_nxt = gpsh_pkg::ST_RATIO_MUL;
      gpsh_pkg::ST_RATIO_MUL: state_nxt = gpsh_pkg::ST_RATIO_UPD;
      gpsh_pkg::ST_RATIO_UPD: state_nxt = gpsh_pkg::ST_PHASE_UPD;
      gpsh_pkg::ST_PHASE_UPD: state_nxt = gpsh_pkg::ST_TAP1;
      gpsh_pkg::ST_TAP1:      state_nxt = gpsh_pkg::ST_TAP2;
      gpsh_pkg::ST_TAP2:      state_nxt = gpsh_pkg::ST_HANN2;
      gpsh_pkg::ST_HANN2:     state_nxt = gpsh_pkg::ST_MAC1;
      gpsh_pkg::ST_MAC1:      state_nxt = gpsh_pkg::ST_MAC2;
      gpsh_pkg::ST_MAC2:      state_nxt = gpsh_pkg::ST_ACC;
      gpsh_pkg::ST_ACC:       state_nxt = gpsh_pkg::ST_GAIN_MUL;
      gpsh_pkg::ST_GAIN_MUL:  state_nxt = gpsh_pkg::ST_OUT;
      gpsh_pkg::ST_OUT:       if (out_free) state_nxt = gpsh_pkg::ST_IDLE;
      default:                state_nxt = gpsh_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      gpsh_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.ld_sample = in_valid;
      end
      gpsh_pkg::ST_RATIO_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = gpsh_pkg::MUL_RATIO;
      end
      gpsh_pkg::ST_RATIO_UPD: begin
        cmd.upd_ratio = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_op    = gpsh_pkg::MUL_GAIN;
      end
      gpsh_pkg::ST_PHASE_UPD: begin
        cmd.upd_phase = 1'b1;
      end
      gpsh_pkg::ST_TAP1: begin
        cmd.ld_tap1 = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_op  = gpsh_pkg::MUL_PHASE1;
      end
      gpsh_pkg::ST_TAP2: begin
        cmd.ld_tap2 = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_op  = gpsh_pkg::MUL_PHASE2;
      end
      gpsh_pkg::ST_HANN2: begin
        cmd.ld_hann2 = 1'b1;
      end
      gpsh_pkg::ST_MAC1: begin
        cmd.ld_d2  = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_op = gpsh_pkg::MUL_TAP1;
      end
      gpsh_pkg::ST_MAC2: begin
        cmd.ld_acc = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_op = gpsh_pkg::MUL_TAP2;
      end
      gpsh_pkg::ST_ACC: begin
        cmd.add_acc = 1'b1;
      end
      gpsh_pkg::ST_GAIN_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = gpsh_pkg::MUL_OUT;
      end
      gpsh_pkg::ST_OUT: begin
        cmd.ld_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/gpsh_datapath.sv -----
// Datapath of the granular pitch shifter: registers, delay memory, Hann table,
// shared multiplier and output register. Depends on gpsh_pkg.
module gpsh_datapath #(
  parameter int DELAY_DEPTH = gpsh_pkg::DELAY_DEPTH_DEF,
  parameter int HANN_DEPTH  = gpsh_pkg::HANN_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic signed [gpsh_pkg::SAMPLE_W-1:0]  in_sample_in,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic signed [gpsh_pkg::SAMPLE_W-1:0]  out_sample_out,
  input  logic                                  cfg_we,
  input  logic [gpsh_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gpsh_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  gpsh_pkg::cmd_t                        cmd,
  output gpsh_pkg::stat_t                       stat
);

  localparam int DW     = $clog2(DELAY_DEPTH);
  localparam int WLC_W  = DW + 1;
  localparam int PH_W   = DW + 1 + gpsh_pkg::FRAC_SH;
  localparam int PS_W   = PH_W + 2;
  localparam int A_W    = (PH_W + 1 > 34) ? PH_W + 1 : 34;
  localparam int PROD_W = A_W + gpsh_pkg::MUL_B_W;
  localparam int HL     = $clog2(HANN_DEPTH);
  localparam int K_LO   = 48 - HL;
  localparam int Y_W    = PROD_W - gpsh_pkg::OUT_SH;
  localparam int SW     = gpsh_pkg::SAMPLE_W;

  // configuration registers
  logic [gpsh_pkg::WLEN_W-1:0]   wlen_r;
  logic [gpsh_pkg::WINV_W-1:0]   winv_r;
  logic [gpsh_pkg::TRATIO_W-1:0] tratio_r;
  logic [gpsh_pkg::TGAIN_W-1:0]  tgain_r;

  // state
  logic [DW-1:0]                 wp_r;
  logic [DW:0]                   fill_r;
  logic [PH_W-1:0]               phase_r;
  logic [PH_W-1:0]               ph2_r;
  logic [gpsh_pkg::RATIO_W-1:0]  ratio_r;
  logic [gpsh_pkg::GAIN_W-1:0]   gain_r;

  // working registers
  logic signed [SW-1:0]            sample_r;
  logic signed [PROD_W-1:0]        prod_r;
  logic [DW-1:0]                   addr_r;
  logic                            ok1_r;
  logic                            ok2_r;
  logic [SW-1:0]                   rd_r;
  logic signed [SW-1:0]            d1_r;
  logic signed [SW-1:0]            d2_r;
  logic [HL-1:0]                   k_r;
  logic [gpsh_pkg::HANN_W-1:0]     hann_r;
  logic signed [gpsh_pkg::ACC_W-1:0] acc_r;
  logic                            out_valid_r;
  logic signed [SW-1:0]            out_data_r;

  logic [SW-1:0]                   mem [DELAY_DEPTH];
  logic [gpsh_pkg::HANN_W-1:0]     hann_tbl [HANN_DEPTH];

  // window length clamped to the legal range, full and half window in phase units
  logic [WLC_W-1:0] wl_c;
  logic [PH_W-1:0]  win;
  logic [PH_W-2:0]  half;

  always_comb begin
    if (wlen_r < gpsh_pkg::WLEN_W'(gpsh_pkg::WIN_MIN)) begin
      wl_c = WLC_W'(gpsh_pkg::WIN_MIN);
    end else if (32'(wlen_r) > 32'(DELAY_DEPTH)) begin
      wl_c = WLC_W'(DELAY_DEPTH);
    end else begin
      wl_c = WLC_W'(wlen_r);
    end
  end

  assign win  = {wl_c, 16'b0};
  assign half = {wl_c, 15'b0};

  // hann table as constant logic
  for (genvar g = 0; g < HANN_DEPTH; g++) begin : g_hann
    assign hann_tbl[g] = gpsh_pkg::hann_q15(g, HL);
  end

  // shared multiplier operand select
  logic signed [gpsh_pkg::RATIO_W:0]  rdiff;
  logic signed [gpsh_pkg::GAIN_W:0]   gdiff;
  logic signed [A_W-1:0]              mul_a;
  logic signed [gpsh_pkg::MUL_B_W-1:0] mul_b;

  assign rdiff = $signed({1'b0, tratio_r, 4'b0}) - $signed({1'b0, ratio_r});
  assign gdiff = $signed({1'b0, tgain_r, 5'b0}) - $signed({1'b0, gain_r});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      gpsh_pkg::MUL_RATIO: begin
        mul_a = A_W'(rdiff);
        mul_b = gpsh_pkg::MUL_B_W'(gpsh_pkg::RATIO_COEF);
      end
      gpsh_pkg::MUL_GAIN: begin
        mul_a = A_W'(gdiff);
        mul_b = gpsh_pkg::MUL_B_W'(gpsh_pkg::GAIN_COEF);
      end
      gpsh_pkg::MUL_PHASE1: begin
        mul_a = $signed(A_W'(phase_r));
        mul_b = $signed(gpsh_pkg::MUL_B_W'(winv_r));
      end
      gpsh_pkg::MUL_PHASE2: begin
        mul_a = $signed(A_W'(ph2_r));
        mul_b = $signed(gpsh_pkg::MUL_B_W'(winv_r));
      end
      gpsh_pkg::MUL_TAP1: begin
        mul_a = A_W'(d1_r);
        mul_b = $signed(gpsh_pkg::MUL_B_W'(hann_r));
      end
      gpsh_pkg::MUL_TAP2: begin
        mul_a = A_W'(d2_r);
        mul_b = $signed(gpsh_pkg::MUL_B_W'(hann_r));
      end
      gpsh_pkg::MUL_OUT: begin
        mul_a = A_W'(acc_r);
        mul_b = $signed(gpsh_pkg::MUL_B_W'(gain_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // glide rounding: add half, arithmetic shift
  logic signed [PROD_W-1:0] glide_rnd;
  assign glide_rnd = (prod_r + PROD_W'(1 << (gpsh_pkg::GLIDE_SH - 1))) >>> gpsh_pkg::GLIDE_SH;

  // phase step and wrap into the window
  logic signed [PS_W-1:0] p0;
  logic signed [PS_W-1:0] p1;
  logic signed [PS_W-1:0] p2;
  logic signed [PS_W-1:0] p3;
  logic signed [PS_W-1:0] win_s;

  assign win_s = $signed(PS_W'(win));

  always_comb begin
    p0 = $signed(PS_W'(phase_r)) + $signed(PS_W'(1 << gpsh_pkg::FRAC_SH))
         - $signed(PS_W'(ratio_r[gpsh_pkg::RATIO_W-1:4]));
    p1 = (p0 > win_s) ? p0 - win_s : p0;
    p2 = (p1 < 0) ? p1 + win_s : p1;
    p3 = (p2 < 0 || p2 > win_s) ? '0 : p2;
  end

  // second tap phase, half a window ahead
  logic [PH_W:0] ph2_s;
  logic [PH_W:0] ph2_w;
  assign ph2_s = (PH_W + 1)'(phase_r) + (PH_W + 1)'(half);
  assign ph2_w = (ph2_s > (PH_W + 1)'(win)) ? ph2_s - (PH_W + 1)'(win) : ph2_s;

  // tap address from the selected phase, wrapped around the store
  logic [PH_W-1:0]        tap_ph;
  logic signed [DW+1:0]   tap_diff;
  logic signed [DW+1:0]   tap_wrap;
  logic [DW-1:0]          tap_idx;
  logic                   tap_ok;

  assign tap_ph   = cmd.ld_tap1 ? phase_r : ph2_r;
  assign tap_diff = $signed((DW + 2)'(wp_r)) - $signed((DW + 2)'(tap_ph[PH_W-1:16]));
  assign tap_wrap = (tap_diff < 0) ? tap_diff + $signed((DW + 2)'(DELAY_DEPTH)) : tap_diff;
  assign tap_idx  = tap_wrap[DW-1:0];
  // entries not yet written since reset read as zero
  assign tap_ok   = ((DW + 1)'(tap_idx) < fill_r);

  // output rounding and saturation
  logic signed [PROD_W-1:0] y_full;
  logic signed [Y_W-1:0]    y;
  logic signed [SW-1:0]     y_sat;

  assign y_full = (prod_r + PROD_W'(64'd1 << (gpsh_pkg::OUT_SH - 1))) >>> gpsh_pkg::OUT_SH;
  assign y      = y_full[Y_W-1:0];

  always_comb begin
    if (y > $signed(Y_W'(32767))) begin
      y_sat = 16'sh7fff;
    end else if (y < -$signed(Y_W'(32768))) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y[SW-1:0];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r   <= gpsh_pkg::WLEN_RST;
      winv_r   <= gpsh_pkg::WINV_RST;
      tratio_r <= gpsh_pkg::TRATIO_RST;
      tgain_r  <= gpsh_pkg::TGAIN_RST;
    end else if (cfg_we) begin
      unique case (gpsh_pkg::cfg_idx_t'(cfg_index))
        gpsh_pkg::CFG_WINDOW_LEN:   wlen_r   <= cfg_data[gpsh_pkg::WLEN_W-1:0];
        gpsh_pkg::CFG_WINDOW_INV:   winv_r   <= cfg_data[gpsh_pkg::WINV_W-1:0];
        gpsh_pkg::CFG_TARGET_RATIO: tratio_r <= cfg_data[gpsh_pkg::TRATIO_W-1:0];
        gpsh_pkg::CFG_TARGET_GAIN:  tgain_r  <= cfg_data[gpsh_pkg::TGAIN_W-1:0];
        default:                    wlen_r   <= wlen_r;
      endcase
    end
  end

  // persistent state: glides, phase, write pointer, fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= gpsh_pkg::RATIO_RST;
      gain_r  <= gpsh_pkg::GAIN_RST;
      phase_r <= '0;
      wp_r    <= '0;
      fill_r  <= '0;
    end else begin
      if (cmd.upd_ratio) begin
        ratio_r <= ratio_r + glide_rnd[gpsh_pkg::RATIO_W-1:0];
        if (fill_r != (DW + 1)'(DELAY_DEPTH)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (cmd.upd_phase) begin
        gain_r  <= gain_r + glide_rnd[gpsh_pkg::GAIN_W-1:0];
        phase_r <= p3[PH_W-1:0];
      end
      if (cmd.ld_out) begin
        wp_r <= (wp_r == DW'(DELAY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
    end
  end

  // delay memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.upd_ratio) begin
      mem[wp_r] <= sample_r;
    end
    rd_r <= mem[addr_r];
  end

  // hann table read, registered
  always_ff @(posedge clk) begin
    hann_r <= hann_tbl[k_r];
  end

  // item working registers
  always_ff @(posedge clk) begin
    if (cmd.ld_sample) begin
      sample_r <= in_sample_in;
    end
    if (cmd.ld_tap1) begin
      ph2_r  <= ph2_w[PH_W-1:0];
      addr_r <= tap_idx;
      ok1_r  <= tap_ok;
    end
    if (cmd.ld_tap2) begin
      k_r    <= prod_r[K_LO +: HL];
      addr_r <= tap_idx;
      ok2_r  <= tap_ok;
    end
    if (cmd.ld_hann2) begin
      k_r  <= prod_r[K_LO +: HL];
      d1_r <= ok1_r ? $signed(rd_r) : '0;
    end
    if (cmd.ld_d2) begin
      d2_r <= ok2_r ? $signed(rd_r) : '0;
    end
    if (cmd.ld_acc) begin
      acc_r <= prod_r[gpsh_pkg::ACC_W-1:0];
    end else if (cmd.add_acc) begin
      acc_r <= acc_r + prod_r[gpsh_pkg::ACC_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_data_r <= y_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;
  assign stat.out_full  = out_valid_r;

endmodule

// ----- hw/rtl/granular_pitch_shifter_unit.sv -----
// Granular pitch shifter, two Hann-weighted taps on a circular delay store.
// Input channel: in_valid / in_ready / in_sample_in (signed Q1.15), one item per sample.
// Output channel: out_valid / out_ready / out_sample_out, one result item per input item.
// Configuration: cfg_we with cfg_index and cfg_data writes window_len (0), window_inv (1),
// target_ratio (2) and target_gain (3); write only while the block is idle.
// The result is loaded into the output register at the end of the controller sequence.
// A new item is accepted only once the last one leaves the sequence that shares one
// multiplier for both glides, both Hann indexes, both tap products and the gain.
// The delay memory has one write and one read port; taps are read in consecutive cycles.
// DELAY_DEPTH and HANN_DEPTH must be powers of two; the block itself does not check this.
// Reset (rst_n low, synchronous) restores register defaults, unity ratio and gain, phase
// and write pointer zero; the store reads as zero until each entry is written, tracked by
// a fill count, so no clearing pass is needed.
// A finished result waits in the output register while out_ready is low; the next item
// is still accepted and worked on, and stalls only at its final step until the register
// frees up.
// Depends on gpsh_pkg, gpsh_ctrl and gpsh_datapath.
module granular_pitch_shifter_unit #(
  parameter int DELAY_DEPTH = gpsh_pkg::DELAY_DEPTH_DEF,
  parameter int HANN_DEPTH  = gpsh_pkg::HANN_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [gpsh_pkg::SAMPLE_W-1:0]  in_sample_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [gpsh_pkg::SAMPLE_W-1:0]  out_sample_out,
  input  logic                                  cfg_we,
  input  logic [gpsh_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gpsh_pkg::CFG_DATA_W-1:0]       cfg_data
);

  gpsh_pkg::cmd_t  cmd;
  gpsh_pkg::stat_t stat;

  // sequencer
  gpsh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  gpsh_datapath #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .HANN_DEPTH  (HANN_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_sample_in   (in_sample_in),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_sample_out (out_sample_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule
